@@ src/assert_macros.svh @@
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with an active-low asynchronous reset disable
`define RBS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that is checked during reset as well
`define RBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/rbs_pkg.sv @@
// types and constants for the ray versus box slab test
// no dependencies
package rbs_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned HalfW    = 30;
  localparam int unsigned TW       = 31;
  localparam int unsigned DiffW    = 35;
  localparam int unsigned MagW     = 33;
  localparam int unsigned FracW    = 16;
  localparam int unsigned DivSteps = MagW + FracW;
  localparam int unsigned QuoW     = DivSteps + 1;
  localparam int unsigned ProdW    = 2 * CoordW;
  localparam int unsigned SumW     = ProdW - FracW + 1;
  localparam int unsigned IdxW     = 3;

  localparam logic [IdxW-1:0] RegCenterX = 3'd0;
  localparam logic [IdxW-1:0] RegCenterY = 3'd1;
  localparam logic [IdxW-1:0] RegCenterZ = 3'd2;
  localparam logic [IdxW-1:0] RegHalfX   = 3'd3;
  localparam logic [IdxW-1:0] RegHalfY   = 3'd4;
  localparam logic [IdxW-1:0] RegHalfZ   = 3'd5;

  localparam logic [HalfW-1:0] HalfReset = 30'd65536;

  typedef struct packed {
    logic signed [CoordW-1:0] origin_x;
    logic signed [CoordW-1:0] origin_y;
    logic signed [CoordW-1:0] origin_z;
    logic signed [CoordW-1:0] dir_x;
    logic signed [CoordW-1:0] dir_y;
    logic signed [CoordW-1:0] dir_z;
  } ray_req_t;

  typedef struct packed {
    logic                     hit;
    logic [TW-1:0]            hit_t;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
  } hit_rsp_t;

  // per-ray data carried beside the dividers
  typedef struct packed {
    logic [2:0]              par;
    logic                    fail;
    logic [2:0][CoordW-1:0]  origin;
    logic [2:0][CoordW-1:0]  dir;
  } side_t;

  // request into the hit point stages
  typedef struct packed {
    logic                    hit;
    logic [TW-1:0]           ts;
    logic [2:0][CoordW-1:0]  origin;
    logic [2:0][CoordW-1:0]  dir;
  } pt_req_t;

endpackage

@@ src/rbs_div.sv @@
// pipelined restoring divider, one quotient bit per stage, truncating
// depends on rbs_pkg
module rbs_div (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic [rbs_pkg::MagW-1:0]               mag_i,
  input  logic                                   neg_i,
  input  logic [rbs_pkg::CoordW-1:0]             den_i,
  output logic signed [rbs_pkg::QuoW-1:0]        quo_o
);

  localparam int unsigned N  = rbs_pkg::DivSteps;
  localparam int unsigned RW = rbs_pkg::CoordW;

  logic [RW-1:0] rem_q [N];
  logic [N-1:0]  nq_q  [N];
  logic [RW-1:0] den_q [N];
  logic          neg_q [N];

  logic [RW-1:0] rem_in [N];
  logic [N-1:0]  nq_in  [N];
  logic [RW-1:0] den_in [N];
  logic          neg_in [N];
  logic [RW:0]   trial  [N];
  logic          ge     [N];

  always_comb begin
    rem_in[0] = '0;
    nq_in[0]  = {mag_i, {rbs_pkg::FracW{1'b0}}};
    den_in[0] = den_i;
    neg_in[0] = neg_i;
    for (int s = 1; s < N; s++) begin
      rem_in[s] = rem_q[s-1];
      nq_in[s]  = nq_q[s-1];
      den_in[s] = den_q[s-1];
      neg_in[s] = neg_q[s-1];
    end
  end

  always_comb begin
    for (int s = 0; s < N; s++) begin
      trial[s] = {rem_in[s], nq_in[s][N-1]};
      ge[s]    = trial[s] >= {1'b0, den_in[s]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < N; s++) begin
        rem_q[s] <= ge[s] ? RW'(trial[s] - {1'b0, den_in[s]}) : trial[s][RW-1:0];
        nq_q[s]  <= {nq_in[s][N-2:0], ge[s]};
        den_q[s] <= den_in[s];
        neg_q[s] <= neg_in[s];
      end
    end
  end

  logic signed [rbs_pkg::QuoW-1:0] quo_mag;
  assign quo_mag = $signed({1'b0, nq_q[N-1]});
  assign quo_o   = neg_q[N-1] ? -quo_mag : quo_mag;

endmodule

@@ src/rbs_delay.sv @@
// valid and data delay line that keeps step with the divider stages
// no dependencies
module rbs_delay #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [Width-1:0] data_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);

  logic [Depth-1:0] valid_q;
  logic [Width-1:0] data_q [Depth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[Depth-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q[0] <= data_i;
      for (int s = 1; s < Depth; s++) begin
        data_q[s] <= data_q[s-1];
      end
    end
  end

  assign valid_o = valid_q[Depth-1];
  assign data_o  = data_q[Depth-1];

endmodule

@@ src/rbs_point.sv @@
// hit point stages: t times direction, then origin add, saturation, output register
// depends on rbs_pkg
module rbs_point (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  rbs_pkg::pt_req_t  req_i,
  output logic              valid_o,
  output rbs_pkg::hit_rsp_t rsp_o
);

  localparam int unsigned CW = rbs_pkg::CoordW;
  localparam int unsigned SW = rbs_pkg::SumW;

  logic                                 mv_q;
  logic                                 mhit_q;
  logic [rbs_pkg::TW-1:0]               mts_q;
  logic [2:0][CW-1:0]                   morg_q;
  logic signed [rbs_pkg::ProdW-1:0]     prod_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else if (en_i) begin
      mv_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mhit_q <= req_i.hit;
      mts_q  <= req_i.ts;
      morg_q <= req_i.origin;
      for (int a = 0; a < 3; a++) begin
        prod_q[a] <= $signed({1'b0, req_i.ts}) * $signed(req_i.dir[a]);
      end
    end
  end

  logic signed [SW-1:0] sum [3];
  logic [CW-1:0]        pt  [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sum[a] = SW'($signed(morg_q[a])) + SW'(prod_q[a] >>> rbs_pkg::FracW);
      if (sum[a] > $signed(SW'({1'b0, {(CW-1){1'b1}}}))) begin
        pt[a] = {1'b0, {(CW-1){1'b1}}};
      end else if (sum[a] < $signed(-SW'({1'b1, {(CW-1){1'b0}}}))) begin
        pt[a] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        pt[a] = sum[a][CW-1:0];
      end
    end
  end

  logic              ov_q;
  rbs_pkg::hit_rsp_t rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en_i) begin
      ov_q <= mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rsp_q.hit     <= mhit_q;
      rsp_q.hit_t   <= mhit_q ? mts_q : '0;
      rsp_q.point_x <= mhit_q ? pt[0] : '0;
      rsp_q.point_y <= mhit_q ? pt[1] : '0;
      rsp_q.point_z <= mhit_q ? pt[2] : '0;
    end
  end

  assign valid_o = ov_q;
  assign rsp_o   = rsp_q;

endmodule

@@ src/ray_box_slab_intersect.sv @@
// top level of the ray versus axis-aligned box slab test
// depends on rbs_pkg, rbs_div, rbs_delay, rbs_point
//
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------
//  ray in   | in_valid_i / in_ready_o  | in_req_i  (ray_req_t)
//  hit out  | out_valid_o / out_ready_i| out_rsp_o (hit_rsp_t)
//  config   | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// one request per cycle while the output register is not stalled
// the slab dividers have 49 stages, one quotient bit per stage
// reset clears valid bits, box centre to zero, half extents to one
// the whole pipeline holds while the output register waits
module ray_box_slab_intersect (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  rbs_pkg::ray_req_t               in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output rbs_pkg::hit_rsp_t               out_rsp_o,
  input  logic                            cfg_we_i,
  input  logic [rbs_pkg::IdxW-1:0]        cfg_idx_i,
  input  logic [rbs_pkg::CoordW-1:0]      cfg_data_i
);

  localparam int unsigned CW = rbs_pkg::CoordW;
  localparam int unsigned HW = rbs_pkg::HalfW;
  localparam int unsigned DW = rbs_pkg::DiffW;
  localparam int unsigned MW = rbs_pkg::MagW;
  localparam int unsigned QW = rbs_pkg::QuoW;

  logic en;
  assign en         = out_ready_i | ~out_valid_o;
  assign in_ready_o = en;

  // configuration
  logic [CW-1:0] center_q [3];
  logic [HW-1:0] half_q   [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        center_q[a] <= '0;
        half_q[a]   <= rbs_pkg::HalfReset;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rbs_pkg::RegCenterX: center_q[0] <= cfg_data_i;
        rbs_pkg::RegCenterY: center_q[1] <= cfg_data_i;
        rbs_pkg::RegCenterZ: center_q[2] <= cfg_data_i;
        rbs_pkg::RegHalfX:   half_q[0]   <= cfg_data_i[HW-1:0];
        rbs_pkg::RegHalfY:   half_q[1]   <= cfg_data_i[HW-1:0];
        rbs_pkg::RegHalfZ:   half_q[2]   <= cfg_data_i[HW-1:0];
        default: ;
      endcase
    end
  end

  // slab differences and divider operands
  logic [CW-1:0]        org [3];
  logic [CW-1:0]        dir [3];
  logic signed [DW-1:0] lo_diff [3];
  logic signed [DW-1:0] hi_diff [3];
  logic [MW-1:0]        lo_mag_d [3];
  logic [MW-1:0]        hi_mag_d [3];
  logic                 lo_neg_d [3];
  logic                 hi_neg_d [3];
  logic [CW-1:0]        den_d [3];
  rbs_pkg::side_t       side_d;

  assign org[0] = in_req_i.origin_x;
  assign org[1] = in_req_i.origin_y;
  assign org[2] = in_req_i.origin_z;
  assign dir[0] = in_req_i.dir_x;
  assign dir[1] = in_req_i.dir_y;
  assign dir[2] = in_req_i.dir_z;

  always_comb begin
    side_d = '0;
    for (int a = 0; a < 3; a++) begin
      lo_diff[a] = DW'($signed(center_q[a])) - $signed(DW'(half_q[a]))
                 - DW'($signed(org[a]));
      hi_diff[a] = DW'($signed(center_q[a])) + $signed(DW'(half_q[a]))
                 - DW'($signed(org[a]));
      lo_mag_d[a] = lo_diff[a][DW-1] ? MW'(-lo_diff[a]) : MW'(lo_diff[a]);
      hi_mag_d[a] = hi_diff[a][DW-1] ? MW'(-hi_diff[a]) : MW'(hi_diff[a]);
      lo_neg_d[a] = lo_diff[a][DW-1] ^ dir[a][CW-1];
      hi_neg_d[a] = hi_diff[a][DW-1] ^ dir[a][CW-1];
      den_d[a]    = dir[a][CW-1] ? -dir[a] : dir[a];
      side_d.par[a]    = (dir[a] == '0);
      side_d.origin[a] = org[a];
      side_d.dir[a]    = dir[a];
      if ((dir[a] == '0) && ((lo_diff[a] > 0) || (hi_diff[a] < 0))) begin
        side_d.fail = 1'b1;
      end
    end
  end

  logic           pv_q;
  logic [MW-1:0]  lo_mag_q [3];
  logic [MW-1:0]  hi_mag_q [3];
  logic           lo_neg_q [3];
  logic           hi_neg_q [3];
  logic [CW-1:0]  den_q    [3];
  rbs_pkg::side_t side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (en) begin
      pv_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lo_mag_q <= lo_mag_d;
      hi_mag_q <= hi_mag_d;
      lo_neg_q <= lo_neg_d;
      hi_neg_q <= hi_neg_d;
      den_q    <= den_d;
      side_q   <= side_d;
    end
  end

  // dividers
  logic signed [QW-1:0] q_lo [3];
  logic signed [QW-1:0] q_hi [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    rbs_div u_div_lo (
      .clk_i (clk_i),
      .en_i  (en),
      .mag_i (lo_mag_q[a]),
      .neg_i (lo_neg_q[a]),
      .den_i (den_q[a]),
      .quo_o (q_lo[a])
    );
    rbs_div u_div_hi (
      .clk_i (clk_i),
      .en_i  (en),
      .mag_i (hi_mag_q[a]),
      .neg_i (hi_neg_q[a]),
      .den_i (den_q[a]),
      .quo_o (q_hi[a])
    );
  end

  logic           dv;
  rbs_pkg::side_t dside;

  rbs_delay #(
    .Width ($bits(rbs_pkg::side_t)),
    .Depth (rbs_pkg::DivSteps)
  ) u_side (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pv_q),
    .data_i  (side_q),
    .valid_o (dv),
    .data_o  (dside)
  );

  // order entry and exit per axis
  logic                 e1v_q;
  logic signed [QW-1:0] entry_q [3];
  logic signed [QW-1:0] exit_q  [3];
  rbs_pkg::side_t       e1side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1v_q <= 1'b0;
    end else if (en) begin
      e1v_q <= dv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        entry_q[a] <= (q_lo[a] > q_hi[a]) ? q_hi[a] : q_lo[a];
        exit_q[a]  <= (q_lo[a] > q_hi[a]) ? q_lo[a] : q_hi[a];
      end
      e1side_q <= dside;
    end
  end

  // combine axes
  logic signed [QW-1:0] t_c;
  logic signed [QW-1:0] tmax_c;
  logic                 tmax_set;
  rbs_pkg::pt_req_t     pt_d;

  always_comb begin
    t_c      = '0;
    tmax_c   = '0;
    tmax_set = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if (!e1side_q.par[a]) begin
        if (entry_q[a] > t_c) begin
          t_c = entry_q[a];
        end
        if (!tmax_set || (exit_q[a] < tmax_c)) begin
          tmax_c = exit_q[a];
        end
        tmax_set = 1'b1;
      end
    end
    pt_d.hit    = ~e1side_q.fail & (~tmax_set | (t_c <= tmax_c));
    pt_d.ts     = (t_c > $signed(QW'({rbs_pkg::TW{1'b1}}))) ? '1 : t_c[rbs_pkg::TW-1:0];
    pt_d.origin = e1side_q.origin;
    pt_d.dir    = e1side_q.dir;
  end

  logic             e2v_q;
  rbs_pkg::pt_req_t pt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e2v_q <= 1'b0;
    end else if (en) begin
      e2v_q <= e1v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pt_q <= pt_d;
    end
  end

  rbs_point u_point (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (e2v_q),
    .req_i   (pt_q),
    .valid_o (out_valid_o),
    .rsp_o   (out_rsp_o)
  );

endmodule

@@ src/rbs_checker.sv @@
// port-level checks for the slab test, bound to the top level
// depends on rbs_pkg and assert_macros.svh
`include "assert_macros.svh"

module rbs_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input rbs_pkg::ray_req_t in_req_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input rbs_pkg::hit_rsp_t out_rsp_o
);

  logic in_wait;
  logic out_wait;
  logic miss_clean;

  assign in_wait    = in_valid_i && !in_ready_o;
  assign out_wait   = out_valid_o && !out_ready_i;
  assign miss_clean = (out_rsp_o.hit_t == '0) && (out_rsp_o.point_x == '0)
                   && (out_rsp_o.point_y == '0) && (out_rsp_o.point_z == '0);

  `RBS_ASSERT(miss_zero_a, clk_i, rst_ni, (out_valid_o && !out_rsp_o.hit) |-> miss_clean, "miss with nonzero fields")
  `RBS_ASSERT(ready_a, clk_i, rst_ni, in_ready_o == !out_wait, "input ready does not follow stall")
  `RBS_ASSERT(out_hold_a, clk_i, rst_ni, out_wait |=> out_valid_o, "result dropped while stalled")
  `RBS_ASSERT(out_stable_a, clk_i, rst_ni, out_wait |=> $stable(out_rsp_o), "result changed while stalled")
  `RBS_ASSERT(in_stable_a, clk_i, rst_ni, in_wait |=> $stable(in_req_i), "request changed while waiting")

endmodule

bind ray_box_slab_intersect rbs_checker u_rbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);
